FILE: rtl/tmbe_pkg.sv
// ----------------------------------------------------------------------------
// tmbe_pkg
// Shared widths, codes, microprogram and saturation helper for the monomial
// basis evaluation core.
// ----------------------------------------------------------------------------
package tmbe_pkg;

  localparam int unsigned MAX_DEGREE_DEF      = 9;
  localparam int unsigned COORD_FRAC_BITS_DEF = 14;
  localparam int unsigned VALUE_FRAC_BITS_DEF = 27;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned DEG_W      = 4;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned WIDE_W     = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEGREE = 1'b0,
    CFG_MODE   = 1'b1
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_VALUE = 2'd0,
    MODE_DDX   = 2'd1,
    MODE_DDY   = 2'd2,
    MODE_ALT   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    OP_WAIT,
    OP_INIT,
    OP_MULX,
    OP_WRX,
    OP_MULY,
    OP_WRY,
    OP_TSEL,
    OP_TMUL,
    OP_EMIT,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_POW_NONE,
    COND_POW_MORE,
    COND_TERM_MORE
  } cond_e;

  localparam int unsigned UC_DEPTH = 10;
  localparam int unsigned UC_AW    = 4;

  typedef logic [UC_AW-1:0] uaddr_t;

  localparam uaddr_t UA_WAIT = 4'd0;
  localparam uaddr_t UA_MULX = 4'd2;
  localparam uaddr_t UA_TSEL = 4'd6;

  typedef struct packed {
    op_e    op;
    cond_e  cond;
    uaddr_t target;
  } ucode_t;

  localparam ucode_t UCODE [UC_DEPTH] = '{
    '{op: OP_WAIT, cond: COND_NEVER,     target: UA_WAIT},
    '{op: OP_INIT, cond: COND_POW_NONE,  target: UA_TSEL},
    '{op: OP_MULX, cond: COND_NEVER,     target: UA_WAIT},
    '{op: OP_WRX,  cond: COND_NEVER,     target: UA_WAIT},
    '{op: OP_MULY, cond: COND_NEVER,     target: UA_WAIT},
    '{op: OP_WRY,  cond: COND_POW_MORE,  target: UA_MULX},
    '{op: OP_TSEL, cond: COND_NEVER,     target: UA_WAIT},
    '{op: OP_TMUL, cond: COND_NEVER,     target: UA_WAIT},
    '{op: OP_EMIT, cond: COND_TERM_MORE, target: UA_TSEL},
    '{op: OP_NOP,  cond: COND_ALWAYS,    target: UA_WAIT}
  };

  typedef struct packed {
    op_e op;
  } ctrl_t;

  typedef struct packed {
    logic hold;
    logic pow_none;
    logic pow_more;
    logic term_more;
  } status_t;

  localparam logic signed [WIDE_W-1:0] VAL_MAX_WIDE = 64'sd2147483647;
  localparam logic signed [WIDE_W-1:0] VAL_MIN_WIDE = -64'sd2147483648;

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > VAL_MAX_WIDE) begin
      r = VAL_MAX_WIDE[VAL_W-1:0];
    end else if (v < VAL_MIN_WIDE) begin
      r = VAL_MIN_WIDE[VAL_W-1:0];
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/tmbe_if.sv
// ----------------------------------------------------------------------------
// tmbe_if
// Valid/ready channels for point words and basis result words.
// ----------------------------------------------------------------------------
interface tmbe_in_if import tmbe_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic                      point_last;

  modport source (output valid, output x_coord, output y_coord, output point_last,
                  input ready);
  modport sink (input valid, input x_coord, input y_coord, input point_last,
                output ready);
endinterface

interface tmbe_out_if import tmbe_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] basis_value;
  logic [IDX_W-1:0]        basis_index;
  logic                    term_last;
  logic                    batch_end;

  modport source (output valid, output basis_value, output basis_index,
                  output term_last, output batch_end, input ready);
  modport sink (input valid, input basis_value, input basis_index,
                input term_last, input batch_end, output ready);
endinterface

FILE: rtl/triangle_monomial_basis_eval_core.sv
// ----------------------------------------------------------------------------
// triangle_monomial_basis_eval_core
// Evaluates the bivariate monomial basis, or its x or y derivative, up to
// the configured total degree for each input point.
//
//   channel   dir   handshake          word
//   in_port   in    valid / ready      x_coord, y_coord, point_last
//   out_port  out   valid / ready      basis_value, basis_index, term_last,
//                                      batch_end
//   cfg       in    cfg_we_i           cfg_idx_i, cfg_data_i
//
// A point has T = (D+1)(D+2)/2 terms at degree D. The shared multiplier
// is used once per power and once per term, and each term passes through
// three microcode steps.
// Reset returns the sequencer to its wait step and clears degree and mode.
// A stalled output holds the sequencer at its emit step; the next point is
// taken while the last word of the previous one still waits.
// ----------------------------------------------------------------------------
module triangle_monomial_basis_eval_core import tmbe_pkg::*; #(
  parameter int unsigned MAX_DEGREE      = MAX_DEGREE_DEF,
  parameter int unsigned COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int unsigned VALUE_FRAC_BITS = VALUE_FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tmbe_in_if.sink               in_port,
  tmbe_out_if.source            out_port
);

  localparam int unsigned KW = $clog2(MAX_DEGREE + 1);

  logic [DEG_W-1:0] degree_q;
  mode_e            mode_q;
  logic [KW-1:0]    deg_sat;
  ctrl_t            ctrl;
  status_t          status;
  logic [IDX_W:0]   tri_w;
  logic [IDX_W-1:0] last_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= '0;
      mode_q   <= MODE_VALUE;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_DEGREE: degree_q <= cfg_data_i[DEG_W-1:0];
        CFG_MODE:   mode_q   <= mode_e'(cfg_data_i[MODE_W-1:0]);
        default: ;
      endcase
    end
  end

  assign deg_sat = (degree_q > DEG_W'(MAX_DEGREE)) ? KW'(MAX_DEGREE) : KW'(degree_q);

  tmbe_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  tmbe_datapath #(
    .MAX_DEGREE      (MAX_DEGREE),
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .VALUE_FRAC_BITS (VALUE_FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .degree_i      (deg_sat),
    .mode_i        (mode_q),
    .in_valid_i    (in_port.valid),
    .in_ready_o    (in_port.ready),
    .x_coord_i     (in_port.x_coord),
    .y_coord_i     (in_port.y_coord),
    .point_last_i  (in_port.point_last),
    .out_valid_o   (out_port.valid),
    .out_ready_i   (out_port.ready),
    .basis_value_o (out_port.basis_value),
    .basis_index_o (out_port.basis_index),
    .term_last_o   (out_port.term_last),
    .batch_end_o   (out_port.batch_end)
  );

  assign tri_w    = (IDX_W + 1)'(deg_sat) * ((IDX_W + 1)'(deg_sat) + (IDX_W + 1)'(3));
  assign last_idx = tri_w[IDX_W:1];

`ifndef SYNTHESIS
  a_batch_end_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_port.valid && out_port.batch_end |-> out_port.term_last)
    else $error("batch end without term last");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_port.valid && out_port.term_last |-> out_port.basis_index == last_idx)
    else $error("term last at wrong basis index");

  a_one_point_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_port.valid && in_port.ready |=> !in_port.ready)
    else $error("second point taken while the first is in work");
`endif

endmodule

FILE: rtl/tmbe_seq.sv
// ----------------------------------------------------------------------------
// tmbe_seq
// Microcode sequencer: step counter, program table and conditional jumps.
// ----------------------------------------------------------------------------
module tmbe_seq import tmbe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  uaddr_t pc_q, pc_d;
  ucode_t uword;
  logic   take;

  assign uword      = UCODE[pc_q];
  assign ctrl_o.op  = uword.op;

  always_comb begin
    case (uword.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_POW_NONE:  take = status_i.pow_none;
      COND_POW_MORE:  take = status_i.pow_more;
      COND_TERM_MORE: take = status_i.term_more;
      default:        take = 1'b0;
    endcase
    if (status_i.hold) begin
      pc_d = pc_q;
    end else if (take) begin
      pc_d = uword.target;
    end else begin
      pc_d = pc_q + uaddr_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= UA_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

FILE: rtl/tmbe_datapath.sv
// ----------------------------------------------------------------------------
// tmbe_datapath
// Power tables, shared multiplier with rounding and saturation, term
// counters and the output register.
// ----------------------------------------------------------------------------
module tmbe_datapath import tmbe_pkg::*; #(
  parameter int unsigned MAX_DEGREE      = MAX_DEGREE_DEF,
  parameter int unsigned COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int unsigned VALUE_FRAC_BITS = VALUE_FRAC_BITS_DEF,
  localparam int unsigned KW             = $clog2(MAX_DEGREE + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ctrl_t                     ctrl_i,
  output status_t                   status_o,
  input  logic [KW-1:0]             degree_i,
  input  mode_e                     mode_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] x_coord_i,
  input  logic signed [COORD_W-1:0] y_coord_i,
  input  logic                      point_last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [VAL_W-1:0]   basis_value_o,
  output logic [IDX_W-1:0]          basis_index_o,
  output logic                      term_last_o,
  output logic                      batch_end_o
);

  localparam int unsigned DEPTH = MAX_DEGREE + 1;
  localparam int unsigned UP    = (VALUE_FRAC_BITS >= COORD_FRAC_BITS) ?
                                  VALUE_FRAC_BITS - COORD_FRAC_BITS : 0;
  localparam int unsigned DN    = (VALUE_FRAC_BITS < COORD_FRAC_BITS) ?
                                  COORD_FRAC_BITS - VALUE_FRAC_BITS : 1;
  localparam logic signed [WIDE_W-1:0] HALF     = 64'sd1 <<< (VALUE_FRAC_BITS - 1);
  localparam logic signed [WIDE_W-1:0] DN_HALF  = 64'sd1 <<< (DN - 1);
  localparam logic signed [VAL_W-1:0]  ONE_VAL  = (VALUE_FRAC_BITS >= 31) ?
                                                  VAL_MAX_WIDE[VAL_W-1:0] :
                                                  VAL_W'(64'sd1 <<< VALUE_FRAC_BITS);

  function automatic logic signed [VAL_W-1:0] round_sat(input logic signed [WIDE_W-1:0] p);
    logic signed [WIDE_W-1:0] s;
    s = (p + HALF) >>> VALUE_FRAC_BITS;
    return sat_val(s);
  endfunction

  function automatic logic signed [VAL_W-1:0] to_value(input logic signed [COORD_W-1:0] c);
    logic signed [WIDE_W-1:0] w;
    logic signed [VAL_W-1:0]  r;
    w = WIDE_W'(c);
    if (VALUE_FRAC_BITS >= COORD_FRAC_BITS) begin
      if (UP >= 32) begin
        if (c > 0) begin
          r = VAL_MAX_WIDE[VAL_W-1:0];
        end else if (c < 0) begin
          r = VAL_MIN_WIDE[VAL_W-1:0];
        end else begin
          r = '0;
        end
      end else begin
        r = sat_val(w <<< UP);
      end
    end else begin
      r = sat_val((w + DN_HALF) >>> DN);
    end
    return r;
  endfunction

  logic signed [VAL_W-1:0]  x_tab_q [DEPTH];
  logic signed [VAL_W-1:0]  y_tab_q [DEPTH];
  logic signed [VAL_W-1:0]  xb_q, yb_q;
  logic signed [WIDE_W-1:0] prod_q;
  logic signed [VAL_W-1:0]  opa_q, opb_q;
  logic                     mul_q;
  logic                     plast_q;
  logic [KW-1:0]            n_q, k_q, j_q;
  logic [IDX_W-1:0]         idx_q;
  logic                     out_valid_q;
  logic signed [VAL_W-1:0]  out_value_q;
  logic [IDX_W-1:0]         out_index_q;
  logic                     out_tlast_q, out_bend_q;

  logic                     in_fire, emit_go, emit_fire, last_term;
  logic [KW-1:0]            a_w, b_w, x_idx, y_idx, fac;
  logic signed [VAL_W-1:0]  x_rd, y_rd, pw, fsat;
  logic signed [KW+VAL_W:0] fprod;
  logic signed [VAL_W-1:0]  opa_d, opb_d;
  logic                     mul_d;
  logic signed [VAL_W-1:0]  mul_a, mul_b;
  logic signed [WIDE_W-1:0] mul_p;

  assign in_ready_o = (ctrl_i.op == OP_WAIT);
  assign in_fire    = in_valid_i && in_ready_o;
  assign emit_go    = !out_valid_q || out_ready_i;
  assign emit_fire  = (ctrl_i.op == OP_EMIT) && emit_go;
  assign last_term  = (k_q == degree_i) && (j_q == k_q);

  assign status_o.hold      = ((ctrl_i.op == OP_WAIT) && !in_fire) ||
                              ((ctrl_i.op == OP_EMIT) && !emit_go);
  assign status_o.pow_none  = (MAX_DEGREE < 2);
  assign status_o.pow_more  = (n_q < KW'(MAX_DEGREE));
  assign status_o.term_more = !last_term;

  assign a_w = k_q - j_q;
  assign b_w = j_q;

  always_comb begin
    x_idx = a_w;
    y_idx = b_w;
    if (mode_i == MODE_DDX && a_w != '0) begin
      x_idx = a_w - KW'(1);
    end
    if (mode_i == MODE_DDY && b_w != '0) begin
      y_idx = b_w - KW'(1);
    end
  end

  assign x_rd  = x_tab_q[x_idx];
  assign y_rd  = y_tab_q[y_idx];
  assign fac   = (mode_i == MODE_DDY) ? b_w : a_w;
  assign pw    = (mode_i == MODE_DDY) ? y_rd : x_rd;
  assign fprod = $signed({1'b0, fac}) * pw;
  assign fsat  = sat_val(WIDE_W'(fprod));

  always_comb begin
    opa_d = x_rd;
    opb_d = y_rd;
    mul_d = 1'b0;
    case (mode_i)
      MODE_DDX: begin
        if (a_w == '0) begin
          opa_d = '0;
        end else begin
          opa_d = fsat;
          mul_d = (b_w != '0);
        end
      end
      MODE_DDY: begin
        opb_d = x_rd;
        if (b_w == '0) begin
          opa_d = '0;
        end else begin
          opa_d = fsat;
          mul_d = (a_w != '0);
        end
      end
      default: begin
        if (a_w == '0) begin
          opa_d = y_rd;
        end else if (b_w == '0) begin
          opa_d = x_rd;
        end else begin
          mul_d = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    case (ctrl_i.op)
      OP_MULX: begin
        mul_a = x_tab_q[n_q - KW'(1)];
        mul_b = xb_q;
      end
      OP_MULY: begin
        mul_a = y_tab_q[n_q - KW'(1)];
        mul_b = yb_q;
      end
      default: begin
        mul_a = opa_q;
        mul_b = opb_q;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_WAIT: begin
        if (in_fire) begin
          xb_q    <= to_value(x_coord_i);
          yb_q    <= to_value(y_coord_i);
          plast_q <= point_last_i;
        end
      end
      OP_INIT: begin
        x_tab_q[0] <= ONE_VAL;
        x_tab_q[1] <= xb_q;
        y_tab_q[0] <= ONE_VAL;
        y_tab_q[1] <= yb_q;
      end
      OP_MULX: prod_q <= mul_p;
      OP_WRX:  x_tab_q[n_q] <= round_sat(prod_q);
      OP_MULY: prod_q <= mul_p;
      OP_WRY:  y_tab_q[n_q] <= round_sat(prod_q);
      OP_TSEL: begin
        opa_q <= opa_d;
        opb_q <= opb_d;
        mul_q <= mul_d;
      end
      OP_TMUL: prod_q <= mul_p;
      default: ;
    endcase
    if (emit_fire) begin
      out_value_q <= mul_q ? round_sat(prod_q) : opa_q;
      out_index_q <= idx_q;
      out_tlast_q <= last_term;
      out_bend_q  <= last_term && plast_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= '0;
      k_q         <= '0;
      j_q         <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.op == OP_INIT) begin
        n_q   <= KW'(2);
        k_q   <= '0;
        j_q   <= '0;
        idx_q <= '0;
      end else if (ctrl_i.op == OP_WRY) begin
        n_q <= n_q + KW'(1);
      end else if (emit_fire) begin
        idx_q <= idx_q + IDX_W'(1);
        if (j_q == k_q) begin
          k_q <= k_q + KW'(1);
          j_q <= '0;
        end else begin
          j_q <= j_q + KW'(1);
        end
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign basis_value_o = out_value_q;
  assign basis_index_o = out_index_q;
  assign term_last_o   = out_tlast_q;
  assign batch_end_o   = out_bend_q;

endmodule
